// ----- sv/pkb_pkg.sv -----
// Package for the packed bit list: request codes, cell command codes, widths and helpers.
`default_nettype none

package pkb_pkg;

   localparam int DEFAULT_CAPACITY = 1024;
   localparam int CELL_BITS = 8;
   localparam int TREE_FANIN = 8;

   localparam int REQ_W = 3;
   localparam int POS_W = 10;
   localparam int LEN_W = 11;

   localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ERASE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SET = 3'd3;
   localparam logic [REQ_W-1:0] REQ_GET = 3'd4;

   localparam logic [1:0] CELL_NOP = 2'd0;
   localparam logic [1:0] CELL_WRITE = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;
   localparam logic [1:0] CELL_DELETE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic value;
   } cell_cmd_type;

   function automatic int tree_levels(input int width);
      int levels;
      int span;
      levels = 1;
      span = TREE_FANIN;
      while (span < width) begin
         span = span * TREE_FANIN;
         levels++;
      end
      return levels;
   endfunction

endpackage

`default_nettype wire

// ----- sv/pkb_cell.sv -----
// One cell of the bit chain: holds a segment of the list and shifts with its neighbors.
`default_nettype none

module pkb_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W = 10
) (
   input  wire logic                 clock,
   input  wire pkb_pkg::cell_cmd_type cmd,
   input  wire logic [IDX_W-1:0]     index,
   input  wire logic                 low_in,
   input  wire logic                 high_in,
   output logic                      low_out,
   output logic                      high_out,
   output logic                      tap
);
   import pkb_pkg::*;

   logic [CELL_BITS-1:0] seg_ff;
   logic [CELL_BITS-1:0] seg_in;
   logic [CELL_BITS+1:0] ext;
   logic [CELL_BITS-1:0] hit;
   logic [CELL_BITS-1:0] above;

   always_comb begin
      ext = {high_in, seg_ff, low_in};
      for (int j = 0; j < CELL_BITS; j++) begin
         hit[j] = IDX_W'(CELL_INDEX * CELL_BITS + j) == index;
         above[j] = IDX_W'(CELL_INDEX * CELL_BITS + j) > index;
      end
   end

   always_comb begin
      seg_in = seg_ff;
      for (int j = 0; j < CELL_BITS; j++) begin
         case (cmd.op)
            CELL_WRITE: begin
               if (hit[j]) seg_in[j] = cmd.value;
            end
            CELL_INSERT: begin
               if (hit[j]) seg_in[j] = cmd.value;
               else if (above[j]) seg_in[j] = ext[j];
            end
            CELL_DELETE: begin
               if (hit[j] || above[j]) seg_in[j] = ext[j+2];
            end
            default: begin
               seg_in[j] = seg_ff[j];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign low_out = seg_ff[0];
   assign high_out = seg_ff[CELL_BITS-1];
   assign tap = |(seg_ff & hit);

endmodule

`default_nettype wire

// ----- sv/pkb_or_tree.sv -----
// Registered OR tree that gathers the selected bit from all cells.
`default_nettype none

module pkb_or_tree #(
   parameter int WIDTH = 128
) (
   input  wire logic             clock,
   input  wire logic [WIDTH-1:0] leaf,
   output logic                  root
);
   import pkb_pkg::*;

   localparam int LEVELS = tree_levels(WIDTH);
   localparam int PAD = TREE_FANIN ** LEVELS;
   localparam int NODES = PAD / TREE_FANIN;

   logic [PAD-1:0] src [LEVELS];
   logic [PAD-1:0] level_in [LEVELS];
   logic [PAD-1:0] level_ff [LEVELS];

   always_comb begin
      src[0] = PAD'(leaf);
      for (int l = 1; l < LEVELS; l++) begin
         src[l] = level_ff[l-1];
      end
   end

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         level_in[l] = '0;
         for (int i = 0; i < NODES; i++) begin
            level_in[l][i] = |src[l][i*TREE_FANIN +: TREE_FANIN];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LEVELS; l++) begin
         level_ff[l] <= level_in[l];
      end
   end

   assign root = level_ff[LEVELS-1][0];

endmodule

`default_nettype wire

// ----- sv/packed_bit_list.sv -----
// Top level of the packed bit list: request control, bit count and the chain of cells.
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    req_type, req_position, req_end_position,
//                                                req_bit_value
//   rsp       out         rsp_valid/rsp_ready    rsp_read_bit, rsp_length, rsp_status
//
// Append, insert, set and rejected requests go from decode straight to the done state;
// a new request is taken only once the done state has handed on the last result.
// Erase stays in the erase state until every removed bit is gone, as the chain moves the tail one place a cycle.
// Get also waits on the registered OR tree, which has a fan-in of 8 (3 levels at 1024 bits).
// Reset clears the count and the control state; the bit store needs no clearing.
// A new request is accepted while a result waits; a stalled result holds the next one back.
`default_nettype none

module packed_bit_list #(
   parameter int CAPACITY_BITS = pkb_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [pkb_pkg::REQ_W-1:0]  req_type,
   input  wire logic [pkb_pkg::POS_W-1:0]  req_position,
   input  wire logic [pkb_pkg::POS_W-1:0]  req_end_position,
   input  wire logic                       req_bit_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_read_bit,
   output logic [pkb_pkg::LEN_W-1:0]       rsp_length,
   output logic                            rsp_status
);
   import pkb_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY_BITS);
   localparam int CNT_W = $clog2(CAPACITY_BITS + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int NUM_CELLS = (CAPACITY_BITS + CELL_BITS - 1) / CELL_BITS;
   localparam int TREE_LEVELS = tree_levels(NUM_CELLS);
   localparam int WAIT_W = $clog2(TREE_LEVELS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_ERASE = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] erase_left_ff, erase_left_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic             rd_ff, rd_in;
   logic             reject_ff, reject_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_read_bit_ff, rsp_read_bit_in;
   logic [LEN_W-1:0] rsp_length_ff, rsp_length_in;
   logic             rsp_status_ff, rsp_status_in;

   logic [REQ_W-1:0] req_type_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] endp_ff;
   logic             bit_ff;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] endp_ext;
   logic [CMP_W-1:0] count_ext;
   logic             full;
   logic             op_ok;
   logic             grow;
   logic             accept;

   cell_cmd_type     cmd;
   logic [IDX_W-1:0] cell_index;
   logic [NUM_CELLS-1:0] cell_low;
   logic [NUM_CELLS-1:0] cell_high;
   logic [NUM_CELLS-1:0] cell_tap;
   logic             tree_root;

   assign req_ready = state_ff == ST_IDLE;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff <= req_type;
         pos_ff <= req_position;
         endp_ff <= req_end_position;
         bit_ff <= req_bit_value;
      end
   end

   always_comb begin
      pos_ext = CMP_W'(pos_ff);
      endp_ext = CMP_W'(endp_ff);
      count_ext = CMP_W'(count_ff);
      full = count_ff == CNT_W'(CAPACITY_BITS);
      case (req_type_ff)
         REQ_APPEND: op_ok = !full;
         REQ_INSERT: op_ok = !full && (pos_ext <= count_ext);
         REQ_ERASE: op_ok = (endp_ext < count_ext) && (endp_ext >= pos_ext);
         REQ_SET, REQ_GET: op_ok = pos_ext < count_ext;
         default: op_ok = 1'b0;
      endcase
      grow = op_ok && ((req_type_ff == REQ_APPEND) || (req_type_ff == REQ_INSERT));
   end

   always_comb begin
      cmd.value = bit_ff;
      cmd.op = CELL_NOP;
      if (state_ff == ST_DECODE && op_ok) begin
         case (req_type_ff)
            REQ_APPEND, REQ_SET: cmd.op = CELL_WRITE;
            REQ_INSERT: cmd.op = CELL_INSERT;
            default: cmd.op = CELL_NOP;
         endcase
      end else if (state_ff == ST_ERASE) begin
         cmd.op = CELL_DELETE;
      end
      cell_index = (req_type_ff == REQ_APPEND) ? count_ff[IDX_W-1:0] : pos_ext[IDX_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      erase_left_in = erase_left_ff;
      wait_in = wait_ff;
      rd_in = rd_ff;
      reject_in = reject_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_read_bit_in = rsp_read_bit_ff;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            rd_in = 1'b0;
            reject_in = !op_ok;
            state_in = ST_DONE;
            if (op_ok) begin
               case (req_type_ff)
                  REQ_APPEND, REQ_INSERT: begin
                     count_in = count_ff + 1'b1;
                  end
                  REQ_ERASE: begin
                     erase_left_in = endp_ff - pos_ff;
                     state_in = ST_ERASE;
                  end
                  REQ_GET: begin
                     wait_in = WAIT_W'(TREE_LEVELS - 1);
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ERASE: begin
            count_in = count_ff - 1'b1;
            erase_left_in = erase_left_ff - 1'b1;
            if (erase_left_ff == '0) state_in = ST_DONE;
         end
         ST_READ: begin
            if (wait_ff == '0) begin
               rd_in = tree_root;
               state_in = ST_DONE;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_read_bit_in = rd_ff;
               rsp_length_in = LEN_W'(count_ff);
               rsp_status_in = reject_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      erase_left_ff <= erase_left_in;
      wait_ff <= wait_in;
      rd_ff <= rd_in;
      reject_ff <= reject_in;
      rsp_read_bit_ff <= rsp_read_bit_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   for (genvar k = 0; k < NUM_CELLS; k++) begin : gen_cell
      logic low_in;
      logic high_in;
      if (k == 0) begin : gen_first
         assign low_in = 1'b0;
      end else begin : gen_mid_low
         assign low_in = cell_high[k-1];
      end
      if (k == NUM_CELLS - 1) begin : gen_last
         assign high_in = 1'b0;
      end else begin : gen_mid_high
         assign high_in = cell_low[k+1];
      end
      pkb_cell #(
         .CELL_INDEX(k),
         .IDX_W(IDX_W)
      ) u_cell (
         .clock(clock),
         .cmd(cmd),
         .index(cell_index),
         .low_in(low_in),
         .high_in(high_in),
         .low_out(cell_low[k]),
         .high_out(cell_high[k]),
         .tap(cell_tap[k])
      );
   end

   pkb_or_tree #(
      .WIDTH(NUM_CELLS)
   ) u_or_tree (
      .clock(clock),
      .leaf(cell_tap),
      .root(tree_root)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_bit = rsp_read_bit_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY_BITS))
      else $error("Bit count exceeds the capacity.");

   a_erase_has_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ERASE |-> count_ext > CMP_W'(erase_left_ff))
      else $error("Erase runs past the end of the list.");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && !op_ok) |=> $stable(count_ff))
      else $error("A rejected request changed the bit count.");

   a_grow_by_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && grow) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Append or insert did not grow the list by one bit.");
`endif

endmodule

`default_nettype wire
